// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define CHK_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tms_pkg.sv -----
package tms_pkg;

    localparam int TAPE_DEPTH_DEF = 32768;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [15:0] TAPE_SIZE_RST = 16'd30000;

    // register indexes on the configuration port
    localparam logic [1:0] REG_CELL_WIDTH = 2'd0;
    localparam logic [1:0] REG_SAFE_MODE  = 2'd1;
    localparam logic [1:0] REG_TAPE_SIZE  = 2'd2;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_SUB   = 2'd1,
        MODE_RIGHT = 2'd2,
        MODE_LEFT  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CW_8  = 2'd0,
        CW_16 = 2'd1,
        CW_32 = 2'd2,
        CW_64 = 2'd3
    } t_cell_width;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_RIGHT  = 3'd1,
        ST_LEFT   = 3'd2,
        ST_ADD    = 3'd3,
        ST_SUB    = 3'd4,
        ST_HALTED = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]  cell_width;
        logic        safe_mode;
        logic [15:0] tape_size;
    } t_cfg;

    typedef struct packed {
        logic clearing;
        logic halted;
    } t_back_stat;

    function automatic logic [63:0] width_mask(input logic [1:0] cw);
        logic [63:0] m;
        case (t_cell_width'(cw))
            CW_8:    m = 64'h0000_0000_0000_00FF;
            CW_16:   m = 64'h0000_0000_0000_FFFF;
            CW_32:   m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

// ----- sv/tms_queue.sv -----
module tms_queue import tms_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [IDX_W-1:0] r_wr, n_wr;
    logic [IDX_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == IDX_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == IDX_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- sv/tms_front.sv -----
module tms_front import tms_pkg::*; #(
    parameter int TAPE_DEPTH = TAPE_DEPTH_DEF,
    parameter int PTR_W      = $clog2(TAPE_DEPTH),
    parameter int ENTRY_W    = 2 + 16 + PTR_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_mode,
    input  logic [15:0]        i_count,
    output logic               o_push,
    input  logic               i_full,
    output logic [ENTRY_W-1:0] o_entry
);

    // count mod depth via reciprocal, exact for 16-bit counts
    localparam longint unsigned RECIP_L =
        ((64'd1 << 32) + 64'(TAPE_DEPTH) - 64'd1) / 64'(TAPE_DEPTH);
    localparam logic [31:0] RECIP = 32'(RECIP_L);
    localparam int PROD_W = 16 + PTR_W + 1;

    logic              r_valid;
    logic [1:0]        r_mode;
    logic [15:0]       r_count;
    logic [15:0]       r_q;
    logic [47:0]       q_prod;
    logic [PROD_W-1:0] qd;
    logic [PROD_W-1:0] rem_full;
    logic              accept;

    assign o_ready  = i_en && (!r_valid || !i_full);
    assign accept   = i_valid && o_ready;
    assign o_push   = r_valid && !i_full;
    assign q_prod   = 48'(i_count) * 48'(RECIP);
    assign qd       = PROD_W'(r_q) * PROD_W'(TAPE_DEPTH);
    assign rem_full = PROD_W'(r_count) - qd;
    assign o_entry  = {r_mode, r_count, rem_full[PTR_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_mode;
            r_count <= i_count;
            r_q     <= q_prod[47:32];
        end
    end

endmodule

// ----- sv/tms_back.sv -----
module tms_back import tms_pkg::*; #(
    parameter int TAPE_DEPTH = TAPE_DEPTH_DEF,
    parameter int PTR_W      = $clog2(TAPE_DEPTH),
    parameter int ENTRY_W    = 2 + 16 + PTR_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    input  logic [ENTRY_W-1:0] i_entry,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [14:0]        o_pointer,
    output logic [63:0]        o_cell_value,
    output t_status            o_status,
    output t_back_stat         o_stat
);

    localparam int SUM_W = ((PTR_W > 16) ? PTR_W : 16) + 1;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(TAPE_DEPTH);
    localparam logic [PTR_W:0]   DEPTH_P = (PTR_W + 1)'(TAPE_DEPTH);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_EXEC  = 3'b010,
        S_LOAD  = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [PTR_W-1:0] r_ptr, n_ptr;
    logic [63:0]      r_cur, n_cur;
    logic             r_halted, n_halted;
    logic [PTR_W-1:0] r_clr_addr, n_clr_addr;

    logic             r_out_valid, n_out_valid;
    logic [PTR_W-1:0] r_out_ptr, n_out_ptr;
    logic [63:0]      r_out_cell, n_out_cell;
    t_status          r_out_status, n_out_status;

    logic [63:0]      r_tape [TAPE_DEPTH];
    logic [63:0]      r_rdata;
    logic             mem_we;
    logic [PTR_W-1:0] mem_wa;
    logic [63:0]      mem_wd;

    t_mode            mode;
    logic [15:0]      count;
    logic [PTR_W-1:0] cnt_mod;
    logic             out_free;
    logic [63:0]      mask;
    logic [63:0]      val;
    logic [64:0]      add_sum;
    logic             add_fail, sub_fail, right_fail, left_fail;
    logic [63:0]      add_new, sub_new;
    logic [SUM_W-1:0] right_sum, tsz, bound;
    logic [PTR_W:0]   rp, lp, rp_wrap, lp_wrap;
    logic [PTR_W+14:0] ptr_ext;

    assign mode     = t_mode'(i_entry[ENTRY_W-1 -: 2]);
    assign count    = i_entry[PTR_W +: 16];
    assign cnt_mod  = i_entry[PTR_W-1:0];
    assign out_free = !r_out_valid || i_ready;

    assign mask     = width_mask(i_cfg.cell_width);
    assign val      = r_cur & mask;
    assign add_sum  = {1'b0, val} + 65'(count);
    assign add_fail = i_cfg.safe_mode && (add_sum > {1'b0, mask});
    assign add_new  = add_sum[63:0] & mask;
    assign sub_fail = i_cfg.safe_mode && (64'(count) > val);
    assign sub_new  = (val - 64'(count)) & mask;

    assign right_sum  = SUM_W'(r_ptr) + SUM_W'(count);
    assign tsz        = SUM_W'(i_cfg.tape_size);
    assign bound      = (tsz < DEPTH_S) ? tsz : DEPTH_S;
    assign right_fail = i_cfg.safe_mode && (right_sum >= bound);
    assign left_fail  = i_cfg.safe_mode && (SUM_W'(count) > SUM_W'(r_ptr));

    assign rp      = (PTR_W + 1)'(r_ptr) + (PTR_W + 1)'(cnt_mod);
    assign rp_wrap = (rp >= DEPTH_P) ? rp - DEPTH_P : rp;
    assign lp      = (PTR_W + 1)'(r_ptr) - (PTR_W + 1)'(cnt_mod);
    assign lp_wrap = lp[PTR_W] ? lp + DEPTH_P : lp;

    always_comb begin
        n_state      = r_state;
        n_ptr        = r_ptr;
        n_cur        = r_cur;
        n_halted     = r_halted;
        n_clr_addr   = r_clr_addr;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_ptr    = r_out_ptr;
        n_out_cell   = r_out_cell;
        n_out_status = r_out_status;
        o_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_wa       = r_ptr;
        mem_wd       = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_wa     = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == PTR_W'(TAPE_DEPTH - 1)) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_valid && out_free) begin
                    o_pop        = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_ptr    = r_ptr;
                    n_out_cell   = val;
                    n_out_status = ST_OK;
                    if (r_halted) begin
                        n_out_status = ST_HALTED;
                    end else begin
                        case (mode)
                            MODE_ADD: begin
                                if (add_fail) begin
                                    n_out_status = ST_ADD;
                                    n_halted     = 1'b1;
                                end else begin
                                    mem_we     = 1'b1;
                                    mem_wd     = add_new;
                                    n_cur      = add_new;
                                    n_out_cell = add_new;
                                end
                            end
                            MODE_SUB: begin
                                if (sub_fail) begin
                                    n_out_status = ST_SUB;
                                    n_halted     = 1'b1;
                                end else begin
                                    mem_we     = 1'b1;
                                    mem_wd     = sub_new;
                                    n_cur      = sub_new;
                                    n_out_cell = sub_new;
                                end
                            end
                            MODE_RIGHT: begin
                                if (right_fail) begin
                                    n_out_status = ST_RIGHT;
                                    n_halted     = 1'b1;
                                end else begin
                                    // result waits for the read of the new cell
                                    n_out_valid = r_out_valid && !i_ready;
                                    n_ptr       = rp_wrap[PTR_W-1:0];
                                    n_state     = S_LOAD;
                                end
                            end
                            default: begin
                                if (left_fail) begin
                                    n_out_status = ST_LEFT;
                                    n_halted     = 1'b1;
                                end else begin
                                    n_out_valid = r_out_valid && !i_ready;
                                    n_ptr       = lp_wrap[PTR_W-1:0];
                                    n_state     = S_LOAD;
                                end
                            end
                        endcase
                    end
                end
            end
            S_LOAD: begin
                if (out_free) begin
                    n_cur        = r_rdata;
                    n_out_valid  = 1'b1;
                    n_out_ptr    = r_ptr;
                    n_out_cell   = r_rdata & mask;
                    n_out_status = ST_OK;
                    n_state      = S_EXEC;
                end
            end
            default: begin
                n_state = S_EXEC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ptr       <= '0;
            r_cur       <= '0;
            r_halted    <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_cur       <= n_cur;
            r_halted    <= n_halted;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_ptr    <= n_out_ptr;
        r_out_cell   <= n_out_cell;
        r_out_status <= n_out_status;
    end

    // tape memory, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tape[mem_wa] <= mem_wd;
        end
        r_rdata <= r_tape[n_ptr];
    end

    assign ptr_ext         = (PTR_W + 15)'(r_out_ptr);
    assign o_valid         = r_out_valid;
    assign o_pointer       = ptr_ext[14:0];
    assign o_cell_value    = r_out_cell;
    assign o_status        = r_out_status;
    assign o_stat.clearing = (r_state == S_CLEAR);
    assign o_stat.halted   = r_halted;

endmodule

// ----- sv/tape_machine_step_core.sv -----
// add and subtract requests pass the front register, the queue and the output register,
// one request per cycle while the output is not stalled; left and right moves wait in
// S_LOAD for the registered read port of the tape memory and take no other request until then
// reset (synchronous, active low) clears pointer, halt flag and queue, then a
// clearing pass over all TAPE_DEPTH cells zeroes the tape; no request is taken meanwhile
`include "assert_macros.svh"

module tape_machine_step_core import tms_pkg::*; #(
    parameter int TAPE_DEPTH = TAPE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // count[15:0]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // pointer[14:0], cell_value[78:15], status[81:79]

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PTR_W   = $clog2(TAPE_DEPTH);
    localparam int ENTRY_W = 2 + 16 + PTR_W;

    t_cfg               r_cfg;
    logic               cfg_wr;
    logic [1:0]         reg_idx;

    logic               f_push;
    logic [ENTRY_W-1:0] f_entry;
    logic               q_full;
    logic               q_valid;
    logic [ENTRY_W-1:0] q_entry;
    logic               b_pop;
    t_back_stat         b_stat;
    logic [14:0]        out_pointer;
    logic [63:0]        out_cell;
    t_status            out_status;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cell_width <= CW_8;
            r_cfg.safe_mode  <= 1'b0;
            r_cfg.tape_size  <= TAPE_SIZE_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_CELL_WIDTH: r_cfg.cell_width <= pwdata[1:0];
                REG_SAFE_MODE:  r_cfg.safe_mode  <= pwdata[0];
                REG_TAPE_SIZE:  r_cfg.tape_size  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CELL_WIDTH: prdata = {30'b0, r_cfg.cell_width};
            REG_SAFE_MODE:  prdata = {31'b0, r_cfg.safe_mode};
            REG_TAPE_SIZE:  prdata = {16'b0, r_cfg.tape_size};
            default:        prdata = '0;
        endcase
    end

    tms_front #(
        .TAPE_DEPTH (TAPE_DEPTH),
        .PTR_W      (PTR_W),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (!b_stat.clearing),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_mode  (s_axis_tuser),
        .i_count (s_axis_tdata),
        .o_push  (f_push),
        .i_full  (q_full),
        .o_entry (f_entry)
    );

    tms_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_entry),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_valid (q_valid),
        .o_data  (q_entry)
    );

    tms_back #(
        .TAPE_DEPTH (TAPE_DEPTH),
        .PTR_W      (PTR_W),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (q_valid),
        .i_entry      (q_entry),
        .o_pop        (b_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_pointer    (out_pointer),
        .o_cell_value (out_cell),
        .o_status     (out_status),
        .o_stat       (b_stat)
    );

    assign m_axis_tdata = {6'b0, out_status, out_cell, out_pointer};

    `CHK_HOLDS(a_no_req_in_clear, i_clk, i_rst_n, b_stat.clearing, !s_axis_tready, "request taken during tape clear")
    `CHK_NEXT(a_halt_sticks, i_clk, i_rst_n, b_stat.halted, b_stat.halted, "halt flag dropped without reset")
    `CHK_HOLDS(a_fault_halts, i_clk, i_rst_n, m_axis_tvalid && (out_status == ST_RIGHT || out_status == ST_LEFT || out_status == ST_ADD || out_status == ST_SUB || out_status == ST_HALTED), b_stat.halted, "fault reported without halt")

endmodule
